// ----- src/sdet_pkg.sv -----
// sdet_pkg: shared constants, codes and types of the sorted entry table
// used by sdet_cell and sorted_dedup_entry_table; no dependencies
package sdet_pkg;

  // table size and derived widths
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RIDX_W      = 8;
  localparam int CMP_W       = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;

  // payload field widths
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int UPTIME_W = 32;
  localparam int TAG_W    = 16;
  localparam int KEY_W    = ADDR_W + PORT_W;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 8;
  localparam int COUNT_W  = 9;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // operation codes
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_INSERTED = 3'd1,
    ST_REPLACED = 3'd2,
    ST_REJECTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_RANGE    = 3'd5
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_SEL  = 2'd2,
    S_DONE = 2'd3
  } state_t;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic [UPTIME_W-1:0] uptime;
    logic [TAG_W-1:0]    tag;
  } entry_t;

  // broadcast command from the controller to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_go;
    logic rep_go;
  } cell_cmd_t;

  // per-cell compare result seen by the controller
  typedef struct packed {
    logic bnd;
    logic eq;
  } cell_flag_t;

endpackage

// ----- src/sdet_cell.sv -----
// sdet_cell: one table slot; compares its key with the broadcast key and
// shifts its entry to the right neighbor on insert; depends on sdet_pkg
module sdet_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sdet_pkg::idx_t      cell_idx,
  input  sdet_pkg::cnt_t      count,
  input  sdet_pkg::cell_cmd_t cmd,
  input  sdet_pkg::entry_t    new_ent,
  input  sdet_pkg::entry_t    left_ent,
  input  logic                left_lt,
  output sdet_pkg::entry_t    ent,
  output logic                lt,
  output sdet_pkg::cell_flag_t flags
);

  sdet_pkg::entry_t ent_r;
  logic             lt_r;
  logic             eq_r;
  logic             occ;
  logic [sdet_pkg::KEY_W-1:0] my_key;
  logic [sdet_pkg::KEY_W-1:0] new_key;
  logic             bnd;

  // slot holds a live entry when its index is below the fill count
  assign occ     = {1'b0, cell_idx} < count;
  assign my_key  = {ent_r.addr, ent_r.port};
  assign new_key = {new_ent.addr, new_ent.port};

  // first slot that is free or whose key is not smaller than the new key
  assign bnd = left_lt && !lt_r;

  // key compare flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      lt_r <= occ && (my_key < new_key);
      eq_r <= occ && (my_key == new_key);
    end
  end

  // entry storage: take new entry at the boundary, shift right past it
  always_ff @(posedge clk) begin
    if (bnd && (cmd.ins_go || cmd.rep_go)) begin
      ent_r <= new_ent;
    end else if (cmd.ins_go && !lt_r) begin
      ent_r <= left_ent;
    end
  end

  assign ent       = ent_r;
  assign lt        = lt_r;
  assign flags.bnd = bnd;
  assign flags.eq  = eq_r;

endmodule

// ----- src/sorted_dedup_entry_table.sv -----
// sorted_dedup_entry_table: top level, controller, row of sdet_cell slots
// and result register; depends on sdet_pkg and sdet_cell
//
// Keeps up to TABLE_DEPTH entries sorted ascending by {addr, port}. Each item
// passes through these steps after acceptance: every slot compares its key at
// once and registers the flags, the slot flags are reduced to a position and
// read data, which are registered, and the commit then applies the shift or
// replace and loads the result. The next item is accepted in the cycle after the
// commit. A new item is taken once the previous one has committed, even while
// its result still waits in the output register; the commit of the following
// item waits until that register is free. Duplicate keys keep the entry with
// the higher uptime (a tie replaces); an insert of a new key into a full table
// is dropped with a full status.
module sorted_dedup_entry_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_addr_key,
  input  logic [15:0] in_port_key,
  input  logic [31:0] in_uptime_in,
  input  logic [15:0] in_record_tag,
  input  logic [7:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [7:0]  out_position,
  output logic [8:0]  out_entry_count,
  output logic [31:0] out_read_addr,
  output logic [15:0] out_read_port,
  output logic [31:0] out_read_uptime,
  output logic [15:0] out_read_tag
);

  localparam int DEPTH = sdet_pkg::TABLE_DEPTH;

  sdet_pkg::state_t    state_r, state_nxt;
  sdet_pkg::cnt_t      count_r, count_nxt;
  sdet_pkg::kind_t     kind_r;
  sdet_pkg::entry_t    op_ent_r;
  logic [sdet_pkg::RIDX_W-1:0] ridx_r;
  sdet_pkg::cell_cmd_t cmd;

  // cell row wiring
  sdet_pkg::entry_t     ent_w   [DEPTH];
  logic                 lt_w    [DEPTH];
  sdet_pkg::cell_flag_t flags_w [DEPTH];
  logic [DEPTH-1:0]     bnd_vec;

  // reduced flags
  logic                 found_r, dup_r;
  sdet_pkg::idx_t       pos_r;
  logic [sdet_pkg::UPTIME_W-1:0] dup_up_r;
  sdet_pkg::entry_t     rd_ent_r;
  logic                 found_c, dup_c;
  sdet_pkg::idx_t       pos_c;
  logic [sdet_pkg::UPTIME_W-1:0] dup_up_c;
  sdet_pkg::entry_t     rd_ent_c;
  logic                 in_range;

  // result register
  logic                 out_valid_r;
  sdet_pkg::status_t    out_status_r;
  logic [sdet_pkg::POS_W-1:0]   out_pos_r;
  logic [sdet_pkg::COUNT_W-1:0] out_count_r;
  sdet_pkg::entry_t     out_rd_r;

  // commit decode
  logic                 done_go;
  logic                 in_fire;
  sdet_pkg::status_t    status_c;
  sdet_pkg::cnt_t       pos_full_c;
  logic [sdet_pkg::POS_W-1:0] pos_out_c;

  assign in_fire = in_valid && in_ready;

  // latch the accepted item
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r          <= sdet_pkg::kind_t'(in_kind);
      op_ent_r.addr   <= in_addr_key;
      op_ent_r.port   <= in_port_key;
      op_ent_r.uptime <= in_uptime_in;
      op_ent_r.tag    <= in_record_tag;
      ridx_r          <= in_read_index;
    end
  end

  // row of cells, each fed by its left neighbor
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      sdet_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (sdet_pkg::IDX_W'(g)),
        .count    (count_r),
        .cmd      (cmd),
        .new_ent  (op_ent_r),
        .left_ent (op_ent_r),
        .left_lt  (1'b1),
        .ent      (ent_w[g]),
        .lt       (lt_w[g]),
        .flags    (flags_w[g])
      );
    end else begin : g_rest
      sdet_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (sdet_pkg::IDX_W'(g)),
        .count    (count_r),
        .cmd      (cmd),
        .new_ent  (op_ent_r),
        .left_ent (ent_w[g-1]),
        .left_lt  (lt_w[g-1]),
        .ent      (ent_w[g]),
        .lt       (lt_w[g]),
        .flags    (flags_w[g])
      );
    end
    assign bnd_vec[g] = flags_w[g].bnd;
  end

  // read index check against fill count
  assign in_range = sdet_pkg::CMP_W'(ridx_r) < sdet_pkg::CMP_W'(count_r);

  // reduce the one-hot boundary and the read hit over the row
  always_comb begin
    found_c  = 1'b0;
    dup_c    = 1'b0;
    pos_c    = '0;
    dup_up_c = '0;
    rd_ent_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      found_c  = found_c | flags_w[i].bnd;
      dup_c    = dup_c | (flags_w[i].bnd & flags_w[i].eq);
      pos_c    = pos_c | (flags_w[i].bnd ? sdet_pkg::IDX_W'(i) : '0);
      dup_up_c = dup_up_c | (flags_w[i].bnd ? ent_w[i].uptime : '0);
      rd_ent_c = rd_ent_c |
                 ((in_range && (sdet_pkg::CMP_W'(i) == sdet_pkg::CMP_W'(ridx_r)))
                  ? ent_w[i] : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sdet_pkg::S_SEL) begin
      found_r  <= found_c;
      dup_r    <= dup_c;
      pos_r    <= pos_c;
      dup_up_r <= dup_up_c;
      rd_ent_r <= rd_ent_c;
    end
  end

  // controller: next state, cell commands and commit decode
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    done_go    = 1'b0;
    count_nxt  = count_r;
    status_c   = sdet_pkg::ST_DONE;
    pos_full_c = '0;
    unique case (state_r)
      sdet_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = sdet_pkg::S_CMP;
        end
      end
      sdet_pkg::S_CMP: begin
        cmd.cmp_en = 1'b1;
        state_nxt  = sdet_pkg::S_SEL;
      end
      sdet_pkg::S_SEL: begin
        state_nxt = sdet_pkg::S_DONE;
      end
      sdet_pkg::S_DONE: begin
        done_go = !out_valid_r || out_ready;
        if (done_go) begin
          state_nxt = sdet_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sdet_pkg::S_IDLE;
      end
    endcase

    // status, position and count for the item in S_DONE
    unique case (kind_r)
      sdet_pkg::KIND_INSERT: begin
        pos_full_c = found_r ? {1'b0, pos_r} : count_r;
        if (found_r && dup_r) begin
          if (dup_up_r > op_ent_r.uptime) begin
            status_c = sdet_pkg::ST_REJECTED;
          end else begin
            status_c   = sdet_pkg::ST_REPLACED;
            cmd.rep_go = done_go;
          end
        end else if (count_r == sdet_pkg::CNT_W'(DEPTH)) begin
          status_c = sdet_pkg::ST_FULL;
        end else begin
          status_c   = sdet_pkg::ST_INSERTED;
          cmd.ins_go = done_go;
          count_nxt  = count_r + sdet_pkg::CNT_W'(1);
        end
      end
      sdet_pkg::KIND_READ: begin
        status_c = in_range ? sdet_pkg::ST_DONE : sdet_pkg::ST_RANGE;
      end
      sdet_pkg::KIND_CLEAR: begin
        count_nxt = '0;
      end
      sdet_pkg::KIND_NONE: begin
        status_c = sdet_pkg::ST_DONE;
      end
      default: begin
        status_c = sdet_pkg::ST_DONE;
      end
    endcase
  end

  // position field of the result
  assign pos_out_c = (kind_r == sdet_pkg::KIND_READ) ? ridx_r
                                                     : sdet_pkg::POS_W'(pos_full_c);

  // state and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdet_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (done_go) begin
        count_r <= count_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_status_r <= status_c;
      out_pos_r    <= pos_out_c;
      out_count_r  <= sdet_pkg::COUNT_W'(count_nxt);
      out_rd_r     <= (kind_r == sdet_pkg::KIND_READ) ? rd_ent_r : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_position    = out_pos_r;
  assign out_entry_count = out_count_r;
  assign out_read_addr   = out_rd_r.addr;
  assign out_read_port   = out_rd_r.port;
  assign out_read_uptime = out_rd_r.uptime;
  assign out_read_tag    = out_rd_r.tag;

`ifndef SYNTHESIS
  // fill count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sdet_pkg::CNT_W'(DEPTH))
    else $error("fill count above table size");

  // sorted table gives at most one insertion boundary
  a_bnd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sdet_pkg::S_SEL) |-> $onehot0(bnd_vec))
    else $error("more than one insertion boundary");

  // a new entry grows the table by exactly one
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_go |=> (count_r == $past(count_r) + sdet_pkg::CNT_W'(1)))
    else $error("insert did not bump the count");

  // a replace never changes the fill count
  a_rep_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rep_go |=> $stable(count_r))
    else $error("replace changed the count");

  // a result is loaded only while the controller commits
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_go |-> (state_r == sdet_pkg::S_DONE) && !in_ready)
    else $error("commit outside the commit state");
`endif

endmodule
